/* hdl/nps_pkg.sv */
// Shared types and codes for the navigation progress supervisor.
// No dependencies; used by nps_step and nav_progress_supervisor_fsm.
package nps_pkg;

  // Configuration port geometry and register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TIME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_DIST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROAD_MODE      = 3'd4;

  // Register reset values
  localparam logic [7:0]  RST_MAX_RETRIES    = 8'd3;
  localparam logic [19:0] RST_STUCK_TIME     = 20'd3000;
  localparam logic [15:0] RST_STUCK_DIST     = 16'd50;
  localparam logic [25:0] RST_STUCK_DIST_UM  = 26'd50000;
  localparam logic [15:0] RST_GOAL_TOLERANCE = 16'd300;

  // Micrometres per millimetre, integration window limit, retry ceiling
  localparam logic [25:0] UM_PER_MM  = 26'd1000;
  localparam logic [31:0] DT_LIMIT   = 32'd1000;
  localparam logic [7:0]  RETRY_CEIL = 8'hFF;

  // Commands
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_NEW_GOAL = 2'd1;

  // Supervisor modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_GO       = 3'd1;
  localparam logic [2:0] MODE_RECOVERY = 3'd2;
  localparam logic [2:0] MODE_ARRIVED  = 3'd3;
  localparam logic [2:0] MODE_ABORT    = 3'd4;

  // Reason codes
  localparam logic [3:0] RSN_RESET         = 4'd0;
  localparam logic [3:0] RSN_NEW_GOAL      = 4'd1;
  localparam logic [3:0] RSN_NO_GOAL       = 4'd2;
  localparam logic [3:0] RSN_ARRIVED_LATCH = 4'd3;
  localparam logic [3:0] RSN_ABORT_LATCH   = 4'd4;
  localparam logic [3:0] RSN_REACHED       = 4'd5;
  localparam logic [3:0] RSN_EXHAUSTED     = 4'd6;
  localparam logic [3:0] RSN_PLAN_BLOCKED  = 4'd7;
  localparam logic [3:0] RSN_NO_ROAD_PROG  = 4'd8;
  localparam logic [3:0] RSN_NO_PROGRESS   = 4'd9;
  localparam logic [3:0] RSN_GO            = 4'd10;
  localparam logic [3:0] RSN_GO_WAITING    = 4'd11;

  typedef struct packed {
    logic [7:0]  max_retries;
    logic [19:0] stuck_time_ms;
    logic [15:0] stuck_dist_mm;
    logic [25:0] stuck_dist_um;
    logic [15:0] goal_tolerance_mm;
    logic        road_mode;
  } nps_cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               has_goal;
    logic               plan_ok;
    logic               estop;
    logic [23:0]        goal_dist_mm;
    logic [31:0]        now_ms;
    logic               odom_ok;
    logic signed [15:0] speed_mm_s;
  } nps_in_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  retry_count;
    logic        fail_active;
    logic [31:0] fail_start_ms;
    logic        progress_valid;
    logic [23:0] best_dist_mm;
    logic [31:0] best_time_ms;
    logic        road_valid;
    logic [47:0] road_advance_um;
    logic [47:0] road_base_um;
    logic [31:0] road_start_ms;
    logic [31:0] road_last_ms;
  } nps_state_t;

  typedef struct packed {
    logic [2:0] nav_state;
    logic [3:0] reason;
    logic [7:0] retries;
  } nps_res_t;

endpackage

/* hdl/nps_step.sv */
// Combinational next-state and result logic for one supervisor word.
// Depends on nps_pkg.
module nps_step (
  input  nps_pkg::nps_cfg_t   cfg,
  input  nps_pkg::nps_in_t    din,
  input  nps_pkg::nps_state_t st,
  output nps_pkg::nps_state_t st_nxt,
  output nps_pkg::nps_res_t   res
);

  // Window test; a start time in the future counts as not elapsed
  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] start,
                                   input logic [19:0] win);
    elapsed = (now >= start) && ((now - start) >= {12'd0, win});
  endfunction

  logic               blocked;
  logic [31:0]        dt;
  logic               dt_ok;
  logic signed [26:0] inc;
  logic [47:0]        adv_new;
  logic [47:0]        adv_diff;
  logic               road_gain;
  logic [24:0]        goal_sum;
  logic               goal_gain;
  logic [7:0]         rc_inc;
  logic               exhaust;

  assign blocked = !din.plan_ok || din.estop;

  // Road advance integration: speed times elapsed ms, only for short positive steps
  assign dt        = din.now_ms - st.road_last_ms;
  assign dt_ok     = (din.now_ms > st.road_last_ms) && (dt < nps_pkg::DT_LIMIT);
  assign inc       = din.speed_mm_s * $signed({1'b0, dt[9:0]});
  assign adv_new   = dt_ok ? (st.road_advance_um + {{21{inc[26]}}, inc}) : st.road_advance_um;
  assign adv_diff  = adv_new - st.road_base_um;
  assign road_gain = $signed(adv_diff) >= $signed({22'd0, cfg.stuck_dist_um});

  // Goal distance ratchet
  assign goal_sum  = {1'b0, din.goal_dist_mm} + {9'd0, cfg.stuck_dist_mm};
  assign goal_gain = goal_sum < {1'b0, st.best_dist_mm};

  // Saturating retry count
  assign rc_inc  = (st.retry_count != nps_pkg::RETRY_CEIL) ? (st.retry_count + 8'd1)
                                                           : st.retry_count;
  assign exhaust = rc_inc > cfg.max_retries;

  always_comb begin
    nps_pkg::nps_state_t nx;
    logic       plan_fail;
    logic       stalled;
    logic       trig;
    logic [3:0] why;
    logic [3:0] rsn;

    nx        = st;
    plan_fail = 1'b0;
    stalled   = 1'b0;
    trig      = 1'b0;
    why       = nps_pkg::RSN_PLAN_BLOCKED;
    rsn       = nps_pkg::RSN_RESET;

    if (din.cmd[1]) begin
      // soft reset, also the unused command
      nx  = '0;
      rsn = nps_pkg::RSN_RESET;
    end else if (din.cmd == nps_pkg::CMD_NEW_GOAL) begin
      if (st.mode == nps_pkg::MODE_ARRIVED || st.mode == nps_pkg::MODE_ABORT) begin
        nx.mode = nps_pkg::MODE_GO;
      end
      nx.retry_count     = 8'd0;
      nx.fail_active     = 1'b0;
      nx.progress_valid  = 1'b0;
      nx.road_valid      = 1'b0;
      nx.road_advance_um = 48'd0;
      nx.road_base_um    = 48'd0;
      nx.road_start_ms   = 32'd0;
      nx.road_last_ms    = 32'd0;
      rsn                = nps_pkg::RSN_NEW_GOAL;
    end else if (!din.has_goal) begin
      nx.mode        = nps_pkg::MODE_IDLE;
      nx.fail_active = 1'b0;
      rsn            = nps_pkg::RSN_NO_GOAL;
    end else if (st.mode == nps_pkg::MODE_ARRIVED) begin
      rsn = nps_pkg::RSN_ARRIVED_LATCH;
    end else if (st.mode == nps_pkg::MODE_ABORT) begin
      rsn = nps_pkg::RSN_ABORT_LATCH;
    end else if (!cfg.road_mode && (din.goal_dist_mm <= {8'd0, cfg.goal_tolerance_mm})) begin
      nx.mode = nps_pkg::MODE_ARRIVED;
      rsn     = nps_pkg::RSN_REACHED;
    end else begin
      // plan-fail timer
      if (blocked) begin
        nx.fail_active = 1'b1;
        if (!st.fail_active) begin
          nx.fail_start_ms = din.now_ms;
        end
        plan_fail = elapsed(din.now_ms, st.fail_active ? st.fail_start_ms : din.now_ms,
                            cfg.stuck_time_ms);
      end else begin
        nx.fail_active = 1'b0;
      end

      if (plan_fail) begin
        trig = 1'b1;
        why  = nps_pkg::RSN_PLAN_BLOCKED;
      end else begin
        if (cfg.road_mode) begin
          // road advance ratchet
          if (!blocked && din.odom_ok) begin
            nx.road_last_ms    = din.now_ms;
            nx.road_advance_um = adv_new;
            if (!st.road_valid) begin
              nx.road_base_um  = adv_new;
              nx.road_start_ms = din.now_ms;
              nx.road_valid    = 1'b1;
            end else if (road_gain) begin
              nx.road_base_um  = adv_new;
              nx.road_start_ms = din.now_ms;
              nx.retry_count   = 8'd0;
            end else begin
              stalled = elapsed(din.now_ms, st.road_start_ms, cfg.stuck_time_ms);
            end
          end
        end else if (!blocked) begin
          // goal distance ratchet
          if (!st.progress_valid || goal_gain) begin
            nx.best_dist_mm   = din.goal_dist_mm;
            nx.best_time_ms   = din.now_ms;
            nx.progress_valid = 1'b1;
          end else begin
            stalled = elapsed(din.now_ms, st.best_time_ms, cfg.stuck_time_ms);
          end
        end

        if (stalled) begin
          trig = 1'b1;
          why  = cfg.road_mode ? nps_pkg::RSN_NO_ROAD_PROG : nps_pkg::RSN_NO_PROGRESS;
        end else begin
          nx.mode = nps_pkg::MODE_GO;
          rsn     = din.plan_ok ? nps_pkg::RSN_GO : nps_pkg::RSN_GO_WAITING;
        end
      end

      // recovery trigger, abort once retries run out
      if (trig) begin
        nx.retry_count    = rc_inc;
        nx.fail_active    = 1'b0;
        nx.progress_valid = 1'b0;
        nx.road_valid     = 1'b0;
        if (exhaust) begin
          nx.mode = nps_pkg::MODE_ABORT;
          rsn     = nps_pkg::RSN_EXHAUSTED;
        end else begin
          nx.mode = nps_pkg::MODE_RECOVERY;
          rsn     = why;
        end
      end
    end

    st_nxt        = nx;
    res.nav_state = nx.mode;
    res.reason    = rsn;
    res.retries   = nx.retry_count;
  end

endmodule

/* hdl/nav_progress_supervisor_fsm.sv */
// Navigation progress supervisor top level: input register, state, result register.
// Depends on nps_pkg and nps_step.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | cmd, goal and plan flags, dist, time, speed
//  out     | output    | out_valid / out_ready | nav_state, reason, retries
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per cycle unless out_ready stalls it; the result register drives out_valid.
// The step logic runs on the input register against the state registers, and state
// and result are written together as the word moves into the result register.
// A stalled result register holds the input register; in_ready stays high while
// that stage is empty. cfg_ready is always high. Reset is synchronous, active low.
module nav_progress_supervisor_fsm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_cmd,
  input  logic                               in_has_goal,
  input  logic                               in_plan_ok,
  input  logic                               in_estop,
  input  logic [23:0]                        in_goal_dist_mm,
  input  logic [31:0]                        in_now_ms,
  input  logic                               in_odom_ok,
  input  logic signed [15:0]                 in_speed_mm_s,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_nav_state,
  output logic [3:0]                         out_reason,
  output logic [7:0]                         out_retries,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  nps_pkg::nps_cfg_t   cfg_r;
  nps_pkg::nps_in_t    in_r;
  logic                in_valid_r;
  nps_pkg::nps_state_t state_r;
  nps_pkg::nps_state_t state_nxt;
  nps_pkg::nps_res_t   res_nxt;
  nps_pkg::nps_res_t   res_r;
  logic                out_valid_r;
  logic                adv;

  // Pipeline flow control
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || adv;

  assign cfg_ready = 1'b1;

  // Configuration registers; the mm threshold is also kept in micrometres
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_retries       <= nps_pkg::RST_MAX_RETRIES;
      cfg_r.stuck_time_ms     <= nps_pkg::RST_STUCK_TIME;
      cfg_r.stuck_dist_mm     <= nps_pkg::RST_STUCK_DIST;
      cfg_r.stuck_dist_um     <= nps_pkg::RST_STUCK_DIST_UM;
      cfg_r.goal_tolerance_mm <= nps_pkg::RST_GOAL_TOLERANCE;
      cfg_r.road_mode         <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        nps_pkg::CFG_MAX_RETRIES:    cfg_r.max_retries   <= cfg_data[7:0];
        nps_pkg::CFG_STUCK_TIME:     cfg_r.stuck_time_ms <= cfg_data;
        nps_pkg::CFG_STUCK_DIST: begin
          cfg_r.stuck_dist_mm <= cfg_data[15:0];
          cfg_r.stuck_dist_um <= {10'd0, cfg_data[15:0]} * nps_pkg::UM_PER_MM;
        end
        nps_pkg::CFG_GOAL_TOLERANCE: cfg_r.goal_tolerance_mm <= cfg_data[15:0];
        nps_pkg::CFG_ROAD_MODE:      cfg_r.road_mode         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r.cmd          <= in_cmd;
      in_r.has_goal     <= in_has_goal;
      in_r.plan_ok      <= in_plan_ok;
      in_r.estop        <= in_estop;
      in_r.goal_dist_mm <= in_goal_dist_mm;
      in_r.now_ms       <= in_now_ms;
      in_r.odom_ok      <= in_odom_ok;
      in_r.speed_mm_s   <= in_speed_mm_s;
    end
  end

  nps_step u_step (
    .cfg    (cfg_r),
    .din    (in_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Supervisor state, updated as a word leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_valid_r && adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_nav_state = res_r.nav_state;
  assign out_reason    = res_r.reason;
  assign out_retries   = res_r.retries;

  // State moves only with a word
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid_r && adv) |=> $stable(state_r))
    else $error("supervisor state changed without a word");

  // A stalled input stage keeps its word
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_r)))
    else $error("input stage dropped a stalled word");

  // Soft reset result is idle with zero retries
  a_reset_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.reason == nps_pkg::RSN_RESET) |->
      (res_r.nav_state == nps_pkg::MODE_IDLE && res_r.retries == 8'd0))
    else $error("reset result not idle");

  // Abort reasons only come with the abort state
  a_abort_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.reason == nps_pkg::RSN_EXHAUSTED ||
                     res_r.reason == nps_pkg::RSN_ABORT_LATCH)) |->
      (res_r.nav_state == nps_pkg::MODE_ABORT))
    else $error("abort reason without abort state");

endmodule

/* verif/tb_nav_progress_supervisor_fsm.sv */
// Self-checking testbench for nav_progress_supervisor_fsm: directed and random tick streams,
// a cycle-free supervisor model that predicts each status word, and a status checker.
// Depends on nps_pkg and the nav_progress_supervisor_fsm RTL.
`timescale 1ns / 100ps

module tb_nav_progress_supervisor_fsm;

  localparam logic [1:0] CMD_SOFT_RESET = 2'd2;
  localparam logic [1:0] CMD_SPARE      = 2'd3;
  localparam int         SETTLE_CYCLES  = 4;

  // Supervisor model: config copy, state copy, and the queue of pending status words
  class supervisor_model;
    logic [7:0]          max_retries;
    logic [19:0]         stuck_time_ms;
    logic [15:0]         stuck_dist_mm;
    logic [15:0]         goal_tol_mm;
    logic                road_mode;
    nps_pkg::nps_state_t st;
    nps_pkg::nps_res_t   pending_status[$];
    int                  error_count;

    function new();
      max_retries   = nps_pkg::RST_MAX_RETRIES;
      stuck_time_ms = nps_pkg::RST_STUCK_TIME;
      stuck_dist_mm = nps_pkg::RST_STUCK_DIST;
      goal_tol_mm   = nps_pkg::RST_GOAL_TOLERANCE;
      road_mode     = 1'b0;
      error_count   = 0;
      clear_state();
    endfunction

    function void clear_state();
      st      = '0;
      st.mode = nps_pkg::MODE_IDLE;
    endfunction

    function void set_reg(logic [nps_pkg::CFG_IDX_W-1:0] idx,
                          logic [nps_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        nps_pkg::CFG_MAX_RETRIES:    max_retries   = data[7:0];
        nps_pkg::CFG_STUCK_TIME:     stuck_time_ms = data[19:0];
        nps_pkg::CFG_STUCK_DIST:     stuck_dist_mm = data[15:0];
        nps_pkg::CFG_GOAL_TOLERANCE: goal_tol_mm   = data[15:0];
        nps_pkg::CFG_ROAD_MODE:      road_mode     = data[0];
        default: ;
      endcase
    endfunction

    // Stall window check; a start time in the future means not elapsed
    function bit window_done(logic [31:0] now, logic [31:0] start);
      return (now >= start) && ((now - start) >= 32'(stuck_time_ms));
    endfunction

    function logic [3:0] raise_recovery(logic [3:0] why);
      if (st.retry_count != nps_pkg::RETRY_CEIL) st.retry_count = st.retry_count + 8'd1;
      st.fail_active    = 1'b0;
      st.progress_valid = 1'b0;
      st.road_valid     = 1'b0;
      if (st.retry_count > max_retries) begin
        st.mode = nps_pkg::MODE_ABORT;
        return nps_pkg::RSN_EXHAUSTED;
      end
      st.mode = nps_pkg::MODE_RECOVERY;
      return why;
    endfunction

    // Step the model on one accepted word and queue the status it should produce
    function void record_tick(nps_pkg::nps_in_t w);
      logic [3:0]         rsn;
      bit                 blocked;
      bit                 plan_fail;
      bit                 stalled;
      longint             dt;
      longint             inc;
      logic signed [47:0] gain;
      logic signed [15:0] spd;
      nps_pkg::nps_res_t  res;
      spd       = w.speed_mm_s;
      blocked   = !w.plan_ok || w.estop;
      plan_fail = 1'b0;
      stalled   = 1'b0;
      if (w.cmd != nps_pkg::CMD_TICK && w.cmd != nps_pkg::CMD_NEW_GOAL) begin
        clear_state();
        rsn = nps_pkg::RSN_RESET;
      end else if (w.cmd == nps_pkg::CMD_NEW_GOAL) begin
        if (st.mode == nps_pkg::MODE_ARRIVED || st.mode == nps_pkg::MODE_ABORT)
          st.mode = nps_pkg::MODE_GO;
        st.retry_count     = '0;
        st.fail_active     = 1'b0;
        st.progress_valid  = 1'b0;
        st.road_valid      = 1'b0;
        st.road_advance_um = '0;
        st.road_base_um    = '0;
        st.road_start_ms   = '0;
        st.road_last_ms    = '0;
        rsn = nps_pkg::RSN_NEW_GOAL;
      end else if (!w.has_goal) begin
        st.mode        = nps_pkg::MODE_IDLE;
        st.fail_active = 1'b0;
        rsn = nps_pkg::RSN_NO_GOAL;
      end else if (st.mode == nps_pkg::MODE_ARRIVED) begin
        rsn = nps_pkg::RSN_ARRIVED_LATCH;
      end else if (st.mode == nps_pkg::MODE_ABORT) begin
        rsn = nps_pkg::RSN_ABORT_LATCH;
      end else if (!road_mode && w.goal_dist_mm <= 24'(goal_tol_mm)) begin
        st.mode = nps_pkg::MODE_ARRIVED;
        rsn = nps_pkg::RSN_REACHED;
      end else begin
        // plan-fail timer runs while blocked
        if (blocked) begin
          if (!st.fail_active) begin
            st.fail_active   = 1'b1;
            st.fail_start_ms = w.now_ms;
          end
          plan_fail = window_done(w.now_ms, st.fail_start_ms);
        end else begin
          st.fail_active = 1'b0;
        end
        if (plan_fail) begin
          rsn = raise_recovery(nps_pkg::RSN_PLAN_BLOCKED);
        end else begin
          if (road_mode) begin
            // road mode: integrate speed over short steps, ratchet on advance
            if (!blocked && w.odom_ok) begin
              dt = longint'({32'd0, w.now_ms}) - longint'({32'd0, st.road_last_ms});
              st.road_last_ms = w.now_ms;
              if (dt > 0 && dt < 1000) begin
                inc = longint'(spd) * dt;
                st.road_advance_um = st.road_advance_um + inc[47:0];
              end
              gain = st.road_advance_um - st.road_base_um;
              if (!st.road_valid) begin
                st.road_base_um  = st.road_advance_um;
                st.road_start_ms = w.now_ms;
                st.road_valid    = 1'b1;
              end else if (longint'(gain) >= longint'(stuck_dist_mm) * 1000) begin
                st.road_base_um  = st.road_advance_um;
                st.road_start_ms = w.now_ms;
                st.retry_count   = '0;
              end else begin
                stalled = window_done(w.now_ms, st.road_start_ms);
              end
            end
          end else if (!blocked) begin
            // goal mode: ratchet on goal distance
            if (!st.progress_valid) begin
              st.best_dist_mm   = w.goal_dist_mm;
              st.best_time_ms   = w.now_ms;
              st.progress_valid = 1'b1;
            end else if (32'(w.goal_dist_mm) + 32'(stuck_dist_mm) < 32'(st.best_dist_mm)) begin
              st.best_dist_mm = w.goal_dist_mm;
              st.best_time_ms = w.now_ms;
            end else begin
              stalled = window_done(w.now_ms, st.best_time_ms);
            end
          end
          if (stalled) begin
            rsn = raise_recovery(road_mode ? nps_pkg::RSN_NO_ROAD_PROG
                                           : nps_pkg::RSN_NO_PROGRESS);
          end else begin
            st.mode = nps_pkg::MODE_GO;
            rsn = w.plan_ok ? nps_pkg::RSN_GO : nps_pkg::RSN_GO_WAITING;
          end
        end
      end
      res.nav_state = st.mode;
      res.reason    = rsn;
      res.retries   = st.retry_count;
      pending_status.push_back(res);
    endfunction

    function void compare_status(nps_pkg::nps_res_t got);
      nps_pkg::nps_res_t want;
      if (pending_status.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: status word with nothing pending: state %0d reason %0d retries %0d",
                   $time, got.nav_state, got.reason, got.retries);
        return;
      end
      want = pending_status.pop_front();
      if (got.nav_state !== want.nav_state || got.reason !== want.reason ||
          got.retries !== want.retries) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: status mismatch (exp/got): state %0d/%0d reason %0d/%0d retries %0d/%0d",
                   $time, want.nav_state, got.nav_state, want.reason, got.reason,
                   want.retries, got.retries);
      end
    endfunction
  endclass

  logic                           clk             = 1'b0;
  logic                           rst_n           = 1'b0;
  logic                           in_valid        = 1'b0;
  logic                           in_ready;
  logic [1:0]                     in_cmd          = '0;
  logic                           in_has_goal     = 1'b0;
  logic                           in_plan_ok      = 1'b0;
  logic                           in_estop        = 1'b0;
  logic [23:0]                    in_goal_dist_mm = '0;
  logic [31:0]                    in_now_ms       = '0;
  logic                           in_odom_ok      = 1'b0;
  logic signed [15:0]             in_speed_mm_s   = '0;
  logic                           out_valid;
  logic                           out_ready       = 1'b0;
  logic [2:0]                     out_nav_state;
  logic [3:0]                     out_reason;
  logic [7:0]                     out_retries;
  logic                           cfg_valid       = 1'b0;
  logic                           cfg_ready;
  logic [nps_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [nps_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

  supervisor_model sup;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  logic [31:0]     mission_ms    = '0;

  nav_progress_supervisor_fsm dut (.*);

  always #5 clk = ~clk;

  // Monitor both channels and drive random receiver stalls
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sup.record_tick({in_cmd, in_has_goal, in_plan_ok, in_estop, in_goal_dist_mm,
                       in_now_ms, in_odom_ok, in_speed_mm_s});
    if (rst_n && out_valid && out_ready)
      sup.compare_status({out_nav_state, out_reason, out_retries});
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one input word, with an optional idle gap first; valid stays up afterwards
  task automatic push_word(input nps_pkg::nps_in_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_cmd          <= w.cmd;
    in_has_goal     <= w.has_goal;
    in_plan_ok      <= w.plan_ok;
    in_estop        <= w.estop;
    in_goal_dist_mm <= w.goal_dist_mm;
    in_now_ms       <= w.now_ms;
    in_odom_ok      <= w.odom_ok;
    in_speed_mm_s   <= w.speed_mm_s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send(input logic [1:0] cmd, input logic gv, input logic pok, input logic es,
                      input logic [23:0] dist_mm, input logic [31:0] now, input logic sv,
                      input logic signed [15:0] spd);
    nps_pkg::nps_in_t w;
    w.cmd          = cmd;
    w.has_goal     = gv;
    w.plan_ok      = pok;
    w.estop        = es;
    w.goal_dist_mm = dist_mm;
    w.now_ms       = now;
    w.odom_ok      = sv;
    w.speed_mm_s   = spd;
    push_word(w);
  endtask

  // Write all five registers back to back; only called with nothing in flight
  task automatic apply_settings(input logic [7:0] mr, input logic [19:0] stime,
                                input logic [15:0] sdist, input logic [15:0] tol,
                                input logic fr);
    logic [nps_pkg::CFG_DATA_W-1:0] vals [5];
    logic [nps_pkg::CFG_IDX_W-1:0]  idxs [5];
    vals = '{20'(mr), stime, 20'(sdist), 20'(tol), 20'(fr)};
    idxs = '{nps_pkg::CFG_MAX_RETRIES, nps_pkg::CFG_STUCK_TIME, nps_pkg::CFG_STUCK_DIST,
             nps_pkg::CFG_GOAL_TOLERANCE, nps_pkg::CFG_ROAD_MODE};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      sup.set_reg(idxs[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait for every pending status word, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sup.pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [1:0] control_cmd();
    case ($urandom_range(2))
      0:       return nps_pkg::CMD_NEW_GOAL;
      1:       return CMD_SOFT_RESET;
      default: return CMD_SPARE;
    endcase
  endfunction

  // Random goal runs: a new goal, then ticks with a moving clock and a mostly falling distance
  task automatic run_random(input int count, input int len_lo, input int len_hi,
                            input int noise_pct, input int block_pct);
    nps_pkg::nps_in_t w;
    int               left;
    int               blk;
    int               drop_max;
    int               drop;
    int               roll;
    logic [23:0]      range_mm;
    left     = 0;
    blk      = 0;
    drop_max = 0;
    range_mm = '0;
    for (int k = 0; k < count; k++) begin
      w    = '0;
      roll = $urandom_range(99);
      if (roll < 70)      mission_ms = mission_ms + $urandom_range(1, 999);
      else if (roll < 80) mission_ms = mission_ms + $urandom_range(1000, 4000);
      else if (roll < 85) mission_ms = mission_ms - $urandom_range(1, 2000);
      else if (roll < 95) mission_ms = mission_ms + $urandom_range(0, 700000);
      else if (roll > 97) mission_ms = $urandom;
      roll = $urandom_range(99);
      if (roll < 4)       range_mm = 24'($urandom);
      else if (roll < 8)  range_mm = 24'($urandom_range(0, 1200));
      else if (roll < 12) range_mm = range_mm + 24'($urandom_range(0, 500));
      else begin
        drop = $urandom_range(0, drop_max);
        range_mm = (range_mm > 24'(drop)) ? range_mm - 24'(drop) : '0;
      end
      if (left == 0) begin
        // open a new goal run with its own obstruction level and pace
        left = $urandom_range(len_lo, len_hi);
        if (block_pct >= 0) blk = block_pct;
        else begin
          case ($urandom_range(2))
            0:       blk = 3;
            1:       blk = 35;
            default: blk = 90;
          endcase
        end
        drop_max = $urandom_range(1) ? 200 : 30;
        range_mm = 24'($urandom_range(400, 200000));
        w.cmd    = ($urandom_range(99) < 90) ? nps_pkg::CMD_NEW_GOAL : control_cmd();
      end else begin
        left--;
        w.cmd = ($urandom_range(99) < noise_pct) ? control_cmd() : nps_pkg::CMD_TICK;
      end
      w.has_goal     = ($urandom_range(99) < 95);
      w.plan_ok      = ($urandom_range(99) >= blk);
      w.estop        = ($urandom_range(99) < 5);
      w.goal_dist_mm = range_mm;
      w.now_ms       = mission_ms;
      w.odom_ok      = ($urandom_range(99) < 90);
      roll = $urandom_range(99);
      if (roll < 70)      w.speed_mm_s = 16'($urandom_range(0, 3000));
      else if (roll < 85) w.speed_mm_s = 16'(0 - $urandom_range(0, 3000));
      else                w.speed_mm_s = 16'($urandom);
      push_word(w);
    end
  endtask

  // Run limit
  initial begin
    #5000000;
    $display("tb_nav_progress_supervisor_fsm: errors");
    $finish;
  end

  initial begin
    sup = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Goal mode at reset settings, sender light and receiver heavy idling
    send_idle_pct = 24;
    recv_idle_pct = 61;
    apply_settings(nps_pkg::RST_MAX_RETRIES, nps_pkg::RST_STUCK_TIME, nps_pkg::RST_STUCK_DIST,
                   nps_pkg::RST_GOAL_TOLERANCE, 1'b0);
    send(nps_pkg::CMD_TICK,     1'b0, 1'b1, 1'b0, 24'd5000,   32'd0,    1'b1, 16'sd0);
    send(nps_pkg::CMD_NEW_GOAL, 1'b1, 1'b1, 1'b0, 24'd0,      32'd0,    1'b0, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'hFFFFFF, 32'd1000, 1'b1, 16'sh7FFF);
    // distance exactly at tolerance, then latched arrival
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd300,    32'd1100, 1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b1, 24'd100,    32'd1200, 1'b1, 16'sd0);
    send(nps_pkg::CMD_NEW_GOAL, 1'b1, 1'b1, 1'b0, 24'd0,      32'd1300, 1'b0, 16'sd0);
    // emergency stop with a feasible plan still reports go
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b1, 24'd10000,  32'd2000, 1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b0, 24'd10000,  32'd4000, 1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b0, 24'd10000,  32'd5000, 1'b1, 16'sd0);
    // time running backwards keeps the window open
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b0, 24'd10000,  32'd100,  1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b0, 24'd10000,  32'd50,   1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b1, 24'd10000,  32'd3100, 1'b1, 16'sd0);
    // burn through the retries into abort
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b0, 24'd10000,  32'd3200, 1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b0, 24'd10000,  32'd6200, 1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b0, 24'd10000,  32'd6300, 1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b0, 1'b0, 24'd10000,  32'd9300, 1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd10000,  32'd9400, 1'b1, 16'sd0);
    send(CMD_SOFT_RESET,        1'b1, 1'b1, 1'b0, 24'd10000,  32'd9500, 1'b1, 16'sd0);
    // goal ratchet: a gain below the step does not refresh and the window runs out
    send(nps_pkg::CMD_NEW_GOAL, 1'b1, 1'b1, 1'b0, 24'd20000, 32'hFFFF_F000, 1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd20000, 32'hFFFF_F000, 1'b1, 16'sh8000);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd19960, 32'hFFFF_FC00, 1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd19950, 32'hFFFF_FFFF, 1'b1, 16'sd0);
    send(CMD_SPARE,             1'b0, 1'b0, 1'b1, 24'd0,     32'd0,         1'b0, 16'sd0);
    run_random(100, 5, 40, 3, -1);
    drain();

    // Road mode, never aborts; integration window edges and ratchet refresh
    apply_settings(8'd255, 20'd200, 16'd5, 16'd0, 1'b1);
    send(nps_pkg::CMD_NEW_GOAL, 1'b1, 1'b1, 1'b0, 24'd0, 32'd0,    1'b1, 16'sd0);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd0, 32'd10,   1'b1, 16'sh7FFF);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd0, 32'd500,  1'b1, 16'sh8000);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd0, 32'd1600, 1'b1, 16'sd100);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd0, 32'd1601, 1'b1, 16'sd10000);
    send(nps_pkg::CMD_TICK,     1'b1, 1'b1, 1'b0, 24'd0, 32'd1602, 1'b1, 16'sd5000);
    run_random(100, 5, 40, 3, -1);
    drain();

    // Swap the idling sides; road mode with every limit at zero
    send_idle_pct = 61;
    recv_idle_pct = 24;
    apply_settings(8'd0, 20'd0, 16'd0, 16'd0, 1'b1);
    run_random(70, 5, 40, 3, -1);
    drain();

    // Long blocked runs to drive the retry count into saturation
    apply_settings(8'd255, 20'd0, 16'd0, 16'd0, 1'b0);
    run_random(300, 290, 300, 0, 95);
    drain();

    // No idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(8'd254, 20'd600000, 16'hFFFF, 16'hFFFF, 1'b0);
    run_random(70, 5, 40, 3, -1);
    drain();

    apply_settings(8'd2, 20'd1500, 16'd300, 16'd1000, 1'b1);
    run_random(70, 5, 40, 3, -1);
    drain();

    apply_settings(8'd1, 20'd100, 16'd10, 16'd1000, 1'b0);
    run_random(60, 5, 40, 3, -1);
    drain();

    repeat (10) @(posedge clk);
    if (sup.error_count == 0 && sup.pending_status.size() == 0)
      $display("tb_nav_progress_supervisor_fsm: clean");
    else
      $display("tb_nav_progress_supervisor_fsm: errors");
    $finish;
  end

endmodule
